@@ rtl/avfp_pkg.sv @@
package avfp_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 10;
  localparam int MAX_BATCH   = 31;
  localparam int CNT_W       = 5;
  localparam int SUM_W       = 18;
  localparam int OFF_W       = 11;
  localparam int VEL_W       = 16;
  localparam int DENS_W      = 16;
  localparam int SPAN_W      = 7;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  // Datapath widths of the batch-end unit
  localparam int NUM_W      = 61;
  localparam int DEN_W      = 30;
  localparam int Y_W        = 54;
  localparam int ROOT_W     = 27;
  localparam int SREM_W     = 31;
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = 61;
  localparam int SQRT_STEPS = 27;

  // Arithmetic constants
  localparam int MID_CODE    = 255;
  localparam int FULL_CODE   = 511;
  localparam int BAND_CENTRE = 256;
  localparam int VEL_SCALE   = 10000;

  // Input modes and result kinds
  localparam logic MODE_CAL = 1'b0;
  localparam logic MODE_VEL = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_COUNT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_SPAN   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AIR_DENSITY = 8'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  calib_count;
    logic [CNT_W-1:0]  mean_count;
    logic [SPAN_W-1:0] dead_span;
    logic [DENS_W-1:0] air_density_q14;
  } cfg_t;

  // One finished batch handed from the front to the back
  typedef struct packed {
    logic                    kind;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        n;
    logic signed [OFF_W-1:0] offset;
  } job_t;

  // New offset reported back to the front
  typedef struct packed {
    logic                    cal_done;
    logic signed [OFF_W-1:0] offset;
  } fb_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } back_state_t;

endpackage

@@ rtl/airflow_velocity_from_pressure_adc.sv @@
// Channel   Direction  Handshake            Payload
// in_       input      in_push / in_full    in_mode, in_sample
// out_      output     out_pop / out_empty  out_kind, out_velocity_q8, out_offset_value
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample is taken whenever the input is not full. A batch end runs in the back unit
// as setup, a 61-step restoring divider and output; a velocity batch adds a multiply
// and a 27-step square root, or inside the zero band goes from setup to output.
// A two-entry queue holds finished batches; after a calibration batch the input stays
// full until the new offset is back, since later samples are corrected by it.
// Reset is synchronous and active low; configuration writes are always ready.
module airflow_velocity_from_pressure_adc (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic                    in_mode,
  input  logic [9:0]              in_sample,
  output logic                    in_full,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic                    out_kind,
  output logic signed [15:0]      out_velocity_q8,
  output logic signed [10:0]      out_offset_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [7:0]              cfg_index,
  input  logic [15:0]             cfg_data
);
  import avfp_pkg::*;

  cfg_t cfg_r;
  job_t q_wjob, q_rjob;
  fb_t  fb;
  logic q_push, q_full, q_pop, q_empty;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.calib_count     <= CNT_W'(10);
      cfg_r.mean_count      <= CNT_W'(20);
      cfg_r.dead_span       <= SPAN_W'(2);
      cfg_r.air_density_q14 <= DENS_W'(19726);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CALIB_COUNT: cfg_r.calib_count     <= cfg_data[CNT_W-1:0];
        REG_MEAN_COUNT:  cfg_r.mean_count      <= cfg_data[CNT_W-1:0];
        REG_DEAD_SPAN:   cfg_r.dead_span       <= cfg_data[SPAN_W-1:0];
        REG_AIR_DENSITY: cfg_r.air_density_q14 <= cfg_data[DENS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  avfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_mode   (in_mode),
    .in_sample (in_sample),
    .in_full   (in_full),
    .cfg       (cfg_r),
    .fb        (fb),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wjob)
  );

  avfp_jobq u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rjob),
    .empty (q_empty)
  );

  avfp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_job            (q_rjob),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_kind         (out_kind),
    .out_velocity_q8  (out_velocity_q8),
    .out_offset_value (out_offset_value),
    .fb               (fb)
  );

  // A new offset only arrives while the input is held off for it.
  a_cal_done_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    fb.cal_done |-> in_full)
    else $error("offset returned while input was open");

  // The front never pushes a batch into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("batch pushed into full queue");

  // A calibration result carries zero velocity.
  a_cal_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_kind == MODE_CAL) |-> out_velocity_q8 == 16'sd0)
    else $error("calibration result with nonzero velocity");

endmodule

@@ rtl/avfp_front.sv @@
module avfp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic                    in_mode,
  input  logic [9:0]              in_sample,
  output logic                    in_full,
  input  avfp_pkg::cfg_t          cfg,
  input  avfp_pkg::fb_t           fb,
  input  logic                    q_full,
  output logic                    q_push,
  output avfp_pkg::job_t          q_job
);
  import avfp_pkg::*;

  logic                    batch_mode_r, batch_mode_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [OFF_W-1:0] off_r, off_nxt;
  logic                    cal_wait_r, cal_wait_nxt;

  logic                    accept, same, done;
  logic signed [SUM_W-1:0] base_sum, term, new_sum, smp_ext;
  logic [CNT_W-1:0]        base_cnt, new_cnt, n_reg, n_eff;

  // Hold off while the queue is full or a new offset is being computed
  assign in_full = cal_wait_r | q_full;
  assign accept  = in_push & ~in_full;

  // Accumulate one sample; a mode change restarts the batch
  always_comb begin
    same     = (in_mode == batch_mode_r);
    base_sum = same ? sum_r : '0;
    base_cnt = same ? cnt_r : '0;
    smp_ext  = $signed({{(SUM_W-SAMPLE_BITS){1'b0}}, in_sample});
    if (in_mode == MODE_CAL) begin
      term = smp_ext - SUM_W'(MID_CODE);
    end else begin
      term = smp_ext - {{(SUM_W-OFF_W){off_r[OFF_W-1]}}, off_r};
    end
    new_sum = base_sum + term;
    new_cnt = base_cnt + CNT_W'(1);
    n_reg   = (in_mode == MODE_CAL) ? cfg.calib_count : cfg.mean_count;
    n_eff   = (n_reg == '0) ? CNT_W'(1) : n_reg;
    done    = (new_cnt >= n_eff);

    q_push       = accept & done;
    q_job.kind   = in_mode;
    q_job.sum    = new_sum;
    q_job.n      = n_eff;
    q_job.offset = off_r;

    batch_mode_nxt = batch_mode_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    off_nxt        = off_r;
    cal_wait_nxt   = cal_wait_r;
    if (accept) begin
      batch_mode_nxt = in_mode;
      sum_nxt        = done ? '0 : new_sum;
      cnt_nxt        = done ? '0 : new_cnt;
      if (done && in_mode == MODE_CAL) begin
        cal_wait_nxt = 1'b1;
      end
    end
    if (fb.cal_done) begin
      off_nxt      = fb.offset;
      cal_wait_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_mode_r <= MODE_CAL;
      sum_r        <= '0;
      cnt_r        <= '0;
      off_r        <= '0;
      cal_wait_r   <= 1'b0;
    end else begin
      batch_mode_r <= batch_mode_nxt;
      sum_r        <= sum_nxt;
      cnt_r        <= cnt_nxt;
      off_r        <= off_nxt;
      cal_wait_r   <= cal_wait_nxt;
    end
  end

endmodule

@@ rtl/avfp_jobq.sv @@
module avfp_jobq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  avfp_pkg::job_t wdata,
  output logic           full,
  input  logic           pop,
  output avfp_pkg::job_t rdata,
  output logic           empty
);
  import avfp_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign rdata = mem_r[rd_ptr_r];

  // Two-entry queue of finished batches
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && !empty) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule

@@ rtl/avfp_back.sv @@
module avfp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  avfp_pkg::cfg_t        cfg,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  avfp_pkg::job_t        q_job,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic                  out_kind,
  output logic signed [15:0]    out_velocity_q8,
  output logic signed [10:0]    out_offset_value,
  output avfp_pkg::fb_t         fb
);
  import avfp_pkg::*;

  back_state_t             state_r, state_nxt;
  job_t                    job_r, job_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [17:0]             a_r, a_nxt;
  logic [20:0]             nd_r, nd_nxt;
  logic                    neg_r, neg_nxt;
  logic [Y_W-1:0]          y_r, y_nxt;
  logic [ROOT_W-1:0]       root_r, root_nxt;
  logic [SREM_W-1:0]       srem_r, srem_nxt;
  logic                    res_valid_r, res_valid_nxt;
  logic                    res_kind_r, res_kind_nxt;
  logic signed [VEL_W-1:0] res_vel_r, res_vel_nxt;
  logic signed [OFF_W-1:0] res_off_r, res_off_nxt;

  // Scratch values
  logic [SUM_W-1:0]        abs_sum;
  logic [13:0]             lo_u, hi_u;
  logic signed [SUM_W-1:0] lo_s, hi_s;
  logic signed [19:0]      diff;
  logic [DENS_W-1:0]       dens;
  logic [31:0]             a10k;
  logic [DEN_W:0]          dtrial;
  logic                    dge;
  logic [SREM_W-1:0]       strial, sshift;
  logic                    sge;
  logic [ROOT_W:0]         rsum;
  logic [ROOT_W-1:0]       mag;
  logic [16:0]             magsat;
  logic [OFF_W-1:0]        qoff;
  logic                    slot_free;

  assign out_empty        = ~res_valid_r;
  assign out_kind         = res_kind_r;
  assign out_velocity_q8  = res_vel_r;
  assign out_offset_value = res_off_r;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    step_nxt      = step_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    den_nxt       = den_r;
    a_nxt         = a_r;
    nd_nxt        = nd_r;
    neg_nxt       = neg_r;
    y_nxt         = y_r;
    root_nxt      = root_r;
    srem_nxt      = srem_r;
    res_valid_nxt = res_valid_r & ~out_pop;
    res_kind_nxt  = res_kind_r;
    res_vel_nxt   = res_vel_r;
    res_off_nxt   = res_off_r;
    q_pop         = 1'b0;
    fb.cal_done   = 1'b0;
    fb.offset     = '0;

    // Band limits, distance from mid scale, density
    abs_sum = job_r.sum[SUM_W-1] ? SUM_W'(-job_r.sum) : SUM_W'(job_r.sum);
    lo_u    = 14'(9'(BAND_CENTRE - 32'(cfg.dead_span)) * job_r.n);
    hi_u    = 14'(9'(BAND_CENTRE + 32'(cfg.dead_span)) * job_r.n);
    lo_s    = $signed({4'b0, lo_u});
    hi_s    = $signed({4'b0, hi_u});
    diff    = {{1{job_r.sum[SUM_W-1]}}, job_r.sum, 1'b0}
              - $signed({6'b0, 14'(9'(FULL_CODE) * job_r.n)});
    dens    = (cfg.air_density_q14 == '0) ? DENS_W'(1) : cfg.air_density_q14;
    a10k    = 32'(a_r * 14'(VEL_SCALE));

    // One restoring division step
    dtrial = {rem_r, num_r[NUM_W-1]};
    dge    = (dtrial >= {1'b0, den_r});

    // One square-root step, two radicand bits at a time
    sshift = {srem_r[SREM_W-3:0], y_r[Y_W-1:Y_W-2]};
    strial = SREM_W'({root_r, 2'b01});
    sge    = (sshift >= strial);

    // Rounding, saturation and offset sign
    rsum   = {1'b0, root_r} + (ROOT_W+1)'(1);
    mag    = rsum[ROOT_W:1];
    if (neg_r) begin
      magsat = (mag > ROOT_W'(32768)) ? 17'd32768 : 17'(mag);
    end else begin
      magsat = (mag > ROOT_W'(32767)) ? 17'd32767 : 17'(mag);
    end
    qoff      = neg_r ? OFF_W'(-num_r[OFF_W-1:0]) : num_r[OFF_W-1:0];
    slot_free = ~res_valid_r | out_pop;

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        step_nxt = '0;
        rem_nxt  = '0;
        if (job_r.kind == MODE_CAL) begin
          neg_nxt   = job_r.sum[SUM_W-1];
          num_nxt   = NUM_W'(abs_sum);
          den_nxt   = DEN_W'(job_r.n);
          state_nxt = ST_DIV;
        end else if (job_r.sum > lo_s && job_r.sum < hi_s) begin
          // Inside the zero band
          neg_nxt   = 1'b0;
          root_nxt  = '0;
          state_nxt = ST_FIN;
        end else begin
          neg_nxt   = diff[19];
          a_nxt     = diff[19] ? 18'(-diff) : 18'(diff);
          nd_nxt    = 21'(job_r.n * dens);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // Quotient wanted is a * 10000 * 2^31 / (511 * n * rho_q14)
        num_nxt   = {a10k[29:0], 31'b0};
        den_nxt   = DEN_W'({nd_r, 9'b0}) - DEN_W'(nd_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = dge ? DEN_W'(dtrial - {1'b0, den_r}) : DEN_W'(dtrial);
        num_nxt  = {num_r[NUM_W-2:0], dge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt = '0;
          if (job_r.kind == MODE_CAL) begin
            state_nxt = ST_FIN;
          end else begin
            y_nxt     = num_nxt[Y_W-1:0];
            root_nxt  = '0;
            srem_nxt  = '0;
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        srem_nxt = sge ? sshift - strial : sshift;
        root_nxt = {root_r[ROOT_W-2:0], sge};
        y_nxt    = {y_r[Y_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          res_valid_nxt = 1'b1;
          res_kind_nxt  = job_r.kind;
          if (job_r.kind == MODE_CAL) begin
            res_vel_nxt = '0;
            res_off_nxt = $signed(qoff);
            fb.cal_done = 1'b1;
            fb.offset   = $signed(qoff);
          end else begin
            res_vel_nxt = neg_r ? $signed(VEL_W'(17'd0 - magsat))
                                : $signed(VEL_W'(magsat));
            res_off_nxt = job_r.offset;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    den_r      <= den_nxt;
    a_r        <= a_nxt;
    nd_r       <= nd_nxt;
    neg_r      <= neg_nxt;
    y_r        <= y_nxt;
    root_r     <= root_nxt;
    srem_r     <= srem_nxt;
    res_kind_r <= res_kind_nxt;
    res_vel_r  <= res_vel_nxt;
    res_off_r  <= res_off_nxt;
  end

endmodule
